// ===== rtl/polynomial_fit_mse_macros.svh =====
// Assertion macros for the polynomial fit checker.
// Expects clk_i and rst_ni (active low) to be visible where a macro is used.
`ifndef POLYNOMIAL_FIT_MSE_MACROS_SVH
`define POLYNOMIAL_FIT_MSE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PFM_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pfm_checker: property violated");

// Next-cycle implication, disabled during reset.
`define PFM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pfm_checker: property violated");

`endif

// ===== rtl/pfm_pkg.sv =====
// Shared types, constants and saturation helpers for polynomial_fit_mse.
// No dependencies.
package pfm_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned ProdW   = 64;
  localparam int unsigned AccW    = 64;
  localparam int unsigned FracW   = 16;
  localparam int unsigned ShW     = ProdW - FracW;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned TermW   = 3;

  localparam logic [CfgIdxW-1:0] CfgTermCount = 3'd7;

  localparam logic signed [DataW-1:0] MaxS32 = 32'sh7fff_ffff;
  localparam logic signed [DataW-1:0] MinS32 = 32'sh8000_0000;

  typedef enum logic [2:0] {
    StIdle,
    StMul,
    StAdd,
    StDiff,
    StSqr,
    StAcc,
    StDiv,
    StWait
  } pfm_state_e;

  typedef struct packed {
    logic                    ovf;
    logic signed [DataW-1:0] val;
  } sat_t;

  // Clamp a 48-bit signed value to signed 32 bits.
  function automatic sat_t sat_s48(input logic signed [ShW-1:0] v);
    sat_t r;
    r.ovf = (v[ShW-1:DataW-1] != {(ShW - DataW + 1){v[ShW-1]}});
    r.val = r.ovf ? (v[ShW-1] ? MinS32 : MaxS32) : v[DataW-1:0];
    return r;
  endfunction

  // Clamp a 33-bit signed sum to signed 32 bits.
  function automatic sat_t sat_s33(input logic signed [DataW:0] v);
    sat_t r;
    r.ovf = (v[DataW] != v[DataW-1]);
    r.val = r.ovf ? (v[DataW] ? MinS32 : MaxS32) : v[DataW-1:0];
    return r;
  endfunction

endpackage

// ===== rtl/pfm_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Standalone; used by polynomial_fit_mse for the final mean.
module pfm_div #(
  parameter int unsigned DIVIDEND_W = 64,
  parameter int unsigned DIVISOR_W  = 17
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  done_o,
  output logic [DIVIDEND_W-1:0] quotient_o
);

  localparam int unsigned CntW = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVISOR_W-1:0]  dvs_q, dvs_d;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  ge;

  always_comb begin
    trial  = {rem_q, quo_q[DIVIDEND_W-1]};
    diff   = trial - {1'b0, dvs_q};
    ge     = (trial >= {1'b0, dvs_q});
    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      cnt_d  = CntW'(DIVIDEND_W - 1);
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      // remainder stays below the divisor, so it fits the divisor width
      rem_d = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo_d = {quo_q[DIVIDEND_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== rtl/polynomial_fit_mse.sv =====
// Top level of the polynomial fit error block: coefficient registers, Horner
// sequencer around one shared 32x32 multiplier, saturating accumulator.
// Depends on pfm_pkg and pfm_div.
//
// Each (x, y) sample is evaluated by Horner's rule in Q16.16, the clamped
// difference to y is squared and added to a saturating 64-bit sum. With the
// term count clamped to at most MAX_TERMS, every Horner step passes through a
// multiply state and a shift/add state on the single shared multiplier, then
// the difference, square and accumulate states follow. A sample marked last
// then starts the bit-serial 64-bit division by the sample count, which must
// finish before the result register loads. in_ready_o is high only between
// samples; a finished result waits in its own output register, so the next
// data set may start before it is taken.
module polynomial_fit_mse
  import pfm_pkg::*;
#(
  parameter int unsigned MAX_TERMS   = 7,
  parameter int unsigned MAX_SAMPLES = 65536
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CfgIdxW-1:0]        cfg_idx_i,
  input  logic [DataW-1:0]          cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [DataW-1:0]   sample_x_i,
  input  logic signed [DataW-1:0]   sample_y_i,
  input  logic                      last_sample_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [AccW-1:0]           mean_sq_error_o,
  output logic                      saturated_o
);

  localparam int unsigned KW   = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int unsigned CntW = $clog2(MAX_SAMPLES + 1);
  localparam logic [TermW-1:0] MaxTerms = TermW'(MAX_TERMS);
  localparam logic [CntW-1:0]  MaxCnt   = CntW'(MAX_SAMPLES);

  pfm_state_e state_q, state_d;

  logic signed [DataW-1:0] coef_q [MAX_TERMS];
  logic [TermW-1:0]        term_q;

  logic signed [DataW-1:0] x_q, x_d;
  logic signed [DataW-1:0] y_q, y_d;
  logic                    last_q, last_d;
  logic signed [DataW-1:0] est_q, est_d;
  logic signed [ProdW-1:0] prod_q, prod_d;
  logic [KW-1:0]           k_q, k_d;
  logic [AccW-1:0]         acc_q, acc_d;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic                    ovf_q, ovf_d;
  logic                    out_valid_q, out_valid_d;
  logic [AccW-1:0]         out_mse_q;
  logic                    out_sat_q;
  logic                    out_load;

  logic [TermW-1:0]        n_eff;
  logic [TermW-1:0]        top_idx;
  logic [TermW-1:0]        k_start;
  logic signed [DataW-1:0] mul_b;
  logic signed [ProdW-1:0] prod;
  logic signed [DataW-1:0] coef_k;
  sat_t                    s_mul;
  sat_t                    s_add;
  sat_t                    s_diff;
  logic signed [DataW:0]   sum_add;
  logic signed [DataW:0]   sum_diff;
  logic [AccW:0]           sum_acc;

  logic                    div_start;
  logic                    div_done;
  logic [AccW-1:0]         div_quo;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_TERMS; i++) begin
        coef_q[i] <= '0;
      end
      term_q <= TermW'(1);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgTermCount) begin
        term_q <= cfg_data_i[TermW-1:0];
      end else if (cfg_idx_i < MaxTerms) begin
        coef_q[cfg_idx_i[KW-1:0]] <= cfg_data_i;
      end
    end
  end

  // shared multiplier: Horner step uses est * x, square uses est * est
  assign mul_b = (state_q == StSqr) ? est_q : x_q;
  assign prod  = est_q * mul_b;

  always_comb begin
    n_eff    = (term_q > MaxTerms) ? MaxTerms : term_q;
    top_idx  = n_eff - 3'd1;
    k_start  = n_eff - 3'd2;
    coef_k   = coef_q[k_q];
    s_mul    = sat_s48(prod_q[ProdW-1:FracW]);
    sum_add  = {s_mul.val[DataW-1], s_mul.val} + {coef_k[DataW-1], coef_k};
    s_add    = sat_s33(sum_add);
    sum_diff = {est_q[DataW-1], est_q} - {y_q[DataW-1], y_q};
    s_diff   = sat_s33(sum_diff);
    sum_acc  = {1'b0, acc_q} + {1'b0, prod_q};

    state_d    = state_q;
    x_d        = x_q;
    y_d        = y_q;
    last_d     = last_q;
    est_d      = est_q;
    prod_d     = prod_q;
    k_d        = k_q;
    acc_d      = acc_q;
    cnt_d      = cnt_q;
    ovf_d      = ovf_q;
    in_ready_o = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;

    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          x_d    = sample_x_i;
          y_d    = sample_y_i;
          last_d = last_sample_i;
          if (n_eff == '0) begin
            est_d   = '0;
            state_d = StDiff;
          end else begin
            est_d   = coef_q[top_idx[KW-1:0]];
            k_d     = k_start[KW-1:0];
            state_d = (n_eff == TermW'(1)) ? StDiff : StMul;
          end
        end
      end
      StMul: begin
        prod_d  = prod;
        state_d = StAdd;
      end
      StAdd: begin
        est_d = s_add.val;
        ovf_d = ovf_q | s_mul.ovf | s_add.ovf;
        if (k_q == '0) begin
          state_d = StDiff;
        end else begin
          k_d     = k_q - 1'b1;
          state_d = StMul;
        end
      end
      StDiff: begin
        est_d   = s_diff.val;
        ovf_d   = ovf_q | s_diff.ovf;
        state_d = StSqr;
      end
      StSqr: begin
        prod_d  = prod;
        state_d = StAcc;
      end
      StAcc: begin
        // the square is never negative, so prod_q reads as unsigned here
        if (sum_acc[AccW]) begin
          acc_d = '1;
          ovf_d = 1'b1;
        end else begin
          acc_d = sum_acc[AccW-1:0];
        end
        if (cnt_q != MaxCnt) begin
          cnt_d = cnt_q + 1'b1;
        end else begin
          ovf_d = 1'b1;
        end
        state_d = last_q ? StDiv : StIdle;
      end
      StDiv: begin
        div_start = 1'b1;
        state_d   = StWait;
      end
      StWait: begin
        // hold until the divider finishes and the result register is free
        if (div_done && (!out_valid_q || out_ready_i)) begin
          out_load = 1'b1;
          acc_d    = '0;
          cnt_d    = '0;
          ovf_d    = 1'b0;
          state_d  = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      acc_q       <= '0;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      acc_q       <= acc_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    last_q <= last_d;
    est_q  <= est_d;
    prod_q <= prod_d;
    k_q    <= k_d;
    if (out_load) begin
      out_mse_q <= div_quo;
      out_sat_q <= ovf_q;
    end
  end

  pfm_div #(
    .DIVIDEND_W (AccW),
    .DIVISOR_W  (CntW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (acc_q),
    .divisor_i  (cnt_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign out_valid_o     = out_valid_q;
  assign mean_sq_error_o = out_mse_q;
  assign saturated_o     = out_sat_q;

endmodule

// ===== rtl/pfm_checker.sv =====
// Port-level checker for polynomial_fit_mse, attached by bind.
// Depends on polynomial_fit_mse_macros.svh.
`include "polynomial_fit_mse_macros.svh"

module pfm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [63:0] mean_sq_error_o,
  input logic        saturated_o
);

  // a stalled result holds its value
  `PFM_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(mean_sq_error_o) && $stable(saturated_o))

  // a sample keeps the block busy for at least the difference and square states
  `PFM_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o ##1 !in_ready_o)

  // a result only appears at the end of a sample's processing
  `PFM_ASSERT_SAME(a_result_from_busy, $rose(out_valid_o), $past(!in_ready_o))

endmodule

bind polynomial_fit_mse pfm_checker u_pfm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .mean_sq_error_o (mean_sq_error_o),
  .saturated_o     (saturated_o)
);

// ===== dv/pfm_fit_checker.sv =====
// Checker for polynomial_fit_mse: it watches the register writes and both
// transaction channels, predicts each result and compares it field by field.
// Depends on pfm_pkg.
module pfm_fit_checker
  import pfm_pkg::*;
#(
  parameter int unsigned MAX_TERMS   = 7,
  parameter int unsigned MAX_SAMPLES = 65536
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxW-1:0]      cfg_idx_i,
  input  logic [DataW-1:0]        cfg_data_i,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  logic signed [DataW-1:0] sample_x_i,
  input  logic signed [DataW-1:0] sample_y_i,
  input  logic                    last_sample_i,
  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  logic [AccW-1:0]         mean_sq_error_i,
  input  logic                    saturated_i,
  output int unsigned             fail_count_o,
  output int unsigned             results_due_o
);

  localparam int NumCoefs = int'(CfgTermCount);
  localparam int CntW     = $clog2(MAX_SAMPLES + 1);

  typedef struct packed {
    logic [AccW-1:0] mse;
    logic            sat;
  } fit_result_t;

  logic signed [DataW-1:0] coef [NumCoefs];
  logic [TermW-1:0]        terms;
  logic [AccW-1:0]         err_sum;
  logic [CntW-1:0]         n_seen;
  logic                    sticky_ovf;
  fit_result_t             due_q [$];

  task automatic report_mismatch(input string what, input logic [AccW-1:0] got,
                                 input logic [AccW-1:0] want);
    $display("pfm_fit_checker: %s mismatch, got %h expected %h at %0t",
             what, got, want, $realtime);
    fail_count_o++;
  endtask

  function automatic logic signed [DataW-1:0] clamp_s32(input longint v);
    if (v > longint'(MaxS32)) begin
      sticky_ovf = 1'b1;
      return MaxS32;
    end
    if (v < longint'(MinS32)) begin
      sticky_ovf = 1'b1;
      return MinS32;
    end
    return v[DataW-1:0];
  endfunction

  // Horner's rule from the highest coefficient in use, clamping after every
  // multiply and every add.
  function automatic logic signed [DataW-1:0] eval_poly(input logic signed [DataW-1:0] x);
    int     n;
    longint est;
    longint prod;
    n = int'(terms);
    if (n > int'(MAX_TERMS)) n = MAX_TERMS;
    if (n > NumCoefs) n = NumCoefs;
    if (n == 0) return '0;
    est = coef[n-1];
    for (int k = n - 2; k >= 0; k--) begin
      prod = est * longint'(x);
      est  = clamp_s32(prod >>> FracW);
      est  = clamp_s32(est + longint'(coef[k]));
    end
    return est[DataW-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    fit_result_t     want;
    longint          d;
    logic [AccW-1:0] sq;
    if (!rst_ni) begin
      for (int k = 0; k < NumCoefs; k++) coef[k] = '0;
      terms        = TermW'(1);
      err_sum      = '0;
      n_seen       = '0;
      sticky_ovf   = 1'b0;
      fail_count_o = 0;
      due_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i < CfgTermCount) coef[cfg_idx_i] = cfg_data_i;
        else if (cfg_idx_i == CfgTermCount) terms = cfg_data_i[TermW-1:0];
      end

      if (out_valid_i && out_ready_i) begin
        if (due_q.size() == 0) begin
          report_mismatch("result with nothing due", mean_sq_error_i, '0);
        end else begin
          want = due_q.pop_front();
          if (mean_sq_error_i !== want.mse)
            report_mismatch("mean_sq_error", mean_sq_error_i, want.mse);
          if (saturated_i !== want.sat)
            report_mismatch("saturated", AccW'(saturated_i), AccW'(want.sat));
        end
      end

      if (in_valid_i && in_ready_i) begin
        d  = clamp_s32(longint'(eval_poly(sample_x_i)) - longint'(sample_y_i));
        sq = AccW'(d * d);
        if (err_sum > ~sq) begin
          err_sum    = '1;
          sticky_ovf = 1'b1;
        end else begin
          err_sum = err_sum + sq;
        end
        // Hold the count at its ceiling and flag the overrun.
        if (n_seen < MAX_SAMPLES) n_seen = n_seen + 1'b1;
        else sticky_ovf = 1'b1;
        if (last_sample_i) begin
          want.mse = err_sum / AccW'(n_seen);
          want.sat = sticky_ovf;
          due_q = {due_q, want};
          err_sum    = '0;
          n_seen     = '0;
          sticky_ovf = 1'b0;
        end
      end
    end
    results_due_o = due_q.size();
  end

endmodule

// ===== dv/tb_top.sv =====
// Top of the polynomial_fit_mse testbench: clock, reset, register loads,
// sample stimulus with idle phases and the final verdict.
// Depends on pfm_pkg, polynomial_fit_mse and pfm_fit_checker.
module tb_top;
  import pfm_pkg::*;

  localparam int unsigned MaxTerms    = 7;
  localparam int unsigned MaxSamples  = 65536;
  localparam int          NumCoefs    = int'(CfgTermCount);
  localparam int unsigned IdleLimit   = 5000;
  localparam int          SettleCycles = 100;
  localparam int          HoldCycles  = 400;
  localparam int          RandomItems = 1850;
  localparam int          NumPhases   = 16;
  localparam int          HoldPhase   = 4;
  localparam int          SmallSpan   = 1 << 18;

  typedef logic signed [DataW-1:0] word_t;
  typedef enum logic [1:0] {SpanSmall, SpanFull, SpanMixed} span_e;

  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]      cfg_idx_i     = '0;
  logic [DataW-1:0]        cfg_data_i    = '0;
  logic                    in_valid_i    = 1'b0;
  logic                    in_ready_o;
  logic signed [DataW-1:0] sample_x_i    = '0;
  logic signed [DataW-1:0] sample_y_i    = '0;
  logic                    last_sample_i = 1'b0;
  logic                    out_valid_o;
  logic                    out_ready_i   = 1'b0;
  logic [AccW-1:0]         mean_sq_error_o;
  logic                    saturated_o;

  int unsigned mismatches;
  int unsigned results_due;
  int          send_idle_pct = 0;
  int          stall_pct     = 0;
  bit          hold_req      = 1'b0;
  word_t       poly [NumCoefs];

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  polynomial_fit_mse #(
    .MAX_TERMS  (MaxTerms),
    .MAX_SAMPLES(MaxSamples)
  ) dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .sample_x_i, .sample_y_i, .last_sample_i,
    .out_valid_o, .out_ready_i, .mean_sq_error_o, .saturated_o
  );

  pfm_fit_checker #(
    .MAX_TERMS  (MaxTerms),
    .MAX_SAMPLES(MaxSamples)
  ) checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .sample_x_i, .sample_y_i, .last_sample_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .mean_sq_error_i(mean_sq_error_o), .saturated_i(saturated_o),
    .fail_count_o(mismatches), .results_due_o(results_due)
  );

  // Result side: random stalls, plus one long hold-off on request.
  initial begin : sink
    bit held;
    held = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !held) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        held = 1'b1;
      end
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < IdleLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic word_t draw(input span_e s);
    int r;
    case (s)
      SpanSmall: begin
        r = int'($urandom_range(2 * SmallSpan));
        return word_t'(r - SmallSpan);
      end
      SpanFull: return word_t'($urandom());
      default: begin
        r = int'($urandom_range(6));
        case (r)
          0: return MaxS32;
          1: return MinS32;
          2: return '0;
          3: return '1;
          4: return word_t'(1);
          5: return draw(SpanSmall);
          default: return draw(SpanFull);
        endcase
      end
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic put_sample(input word_t x, input word_t y, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    sample_x_i    <= x;
    sample_y_i    <= y;
    last_sample_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // Drop valid, wait out every pending result and the tail of the block.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (results_due != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic load_poly(input logic [TermW-1:0] n);
    logic [DataW-1:0] w;
    for (int k = 0; k < NumCoefs; k++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= CfgIdxW'(k);
      cfg_data_i <= poly[k];
      @(negedge clk_i);
    end
    // Upper bits of the term count write are don't-care; randomize them.
    w = $urandom();
    w[TermW-1:0] = n;
    cfg_idx_i  <= CfgTermCount;
    cfg_data_i <= w;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin : stimulus
    int          sent;
    int          len;
    int          mode;
    span_e       span;
    logic [TermW-1:0] n;

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset configuration: single constant term of zero.
    put_sample(32'sh0003_0000, 32'sh0001_8000, 1'b0);
    put_sample(draw(SpanFull), draw(SpanFull), 1'b1);

    // Extreme coefficients at full degree.
    settle();
    poly = '{MaxS32, MinS32, MaxS32, MinS32, word_t'(1), '1, MaxS32};
    load_poly(TermW'(7));
    put_sample(MaxS32, MinS32, 1'b0);
    put_sample(MinS32, MaxS32, 1'b0);
    put_sample('0, '0, 1'b0);
    put_sample('1, word_t'(1), 1'b1);

    // No terms: the estimate is zero, so y at the minimum clamps the difference.
    settle();
    load_poly('0);
    put_sample(draw(SpanFull), MinS32, 1'b1);
    put_sample(draw(SpanFull), MaxS32, 1'b1);

    // Small quadratic with negative x to exercise the floor on the shift.
    settle();
    poly = '{32'sh0001_8000, 32'shFFFF_4000, 32'sh0000_0001, '0, '0, '0, '0};
    load_poly(TermW'(3));
    put_sample('1, 32'sh0000_0003, 1'b0);
    put_sample(32'shFFFE_8000, 32'shFFFF_0000, 1'b0);
    put_sample(32'sh0002_0000, 32'sh0000_8000, 1'b1);

    // Largest difference five times over: the sum clamps at all ones.
    settle();
    poly = '{MaxS32, '0, '0, '0, '0, '0, '0};
    load_poly(TermW'(1));
    for (int i = 0; i < 5; i++) put_sample(draw(SpanFull), MinS32, i == 4);

    for (int phase = 0; phase < NumPhases; phase++) begin
      settle();
      mode = phase % 4;
      send_idle_pct = (mode == 1 || mode == 3) ? ((mode == 1) ? 49 : 6) : 0;
      stall_pct     = (mode == 2 || mode == 3) ? ((mode == 2) ? 49 : 6) : 0;
      len  = int'($urandom_range(9));
      span = (len < 5) ? SpanSmall : ((len < 8) ? SpanMixed : SpanFull);
      for (int k = 0; k < NumCoefs; k++) poly[k] = draw(span);
      n = (phase == 0) ? TermW'(7) : ((phase == 1) ? '0 : TermW'($urandom_range(7)));
      load_poly(n);
      if (phase == HoldPhase) hold_req = 1'b1;
      sent = 0;
      while (sent < RandomItems / NumPhases) begin
        if (phase == HoldPhase) len = int'($urandom_range(1, 3));
        else if ($urandom_range(9) == 0) len = int'($urandom_range(9, 24));
        else len = int'($urandom_range(1, 8));
        for (int i = 0; i < len; i++) put_sample(draw(span), draw(span), i == len - 1);
        sent += len;
      end
    end

    // Close with a short data set at full rate.
    settle();
    send_idle_pct = 0;
    stall_pct     = 0;
    poly = '{draw(SpanSmall), draw(SpanFull), '0, '0, '0, '0, '0};
    load_poly(TermW'(1));
    for (int i = 0; i < 3; i++) put_sample(draw(SpanFull), draw(SpanSmall), i == 2);

    settle();
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/pfm_pkg.sv
rtl/pfm_div.sv
rtl/polynomial_fit_mse.sv
rtl/pfm_checker.sv
dv/pfm_fit_checker.sv
dv/tb_top.sv
